[rtl/gpe_pkg.sv]
// Shared types and constants for the GPIO port with edge interrupts.
package gpe_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [7:0] ADDR_IN   = 8'h20;
    localparam logic [7:0] ADDR_OUT  = 8'h21;
    localparam logic [7:0] ADDR_DIR  = 8'h22;
    localparam logic [7:0] ADDR_IFG  = 8'h23;
    localparam logic [7:0] ADDR_IES  = 8'h24;
    localparam logic [7:0] ADDR_IE   = 8'h25;
    localparam logic [7:0] ADDR_SEL  = 8'h26;
    localparam logic [7:0] ADDR_REN  = 8'h27;
    localparam logic [7:0] ADDR_SEL2 = 8'h41;

    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_ON   = 2'd1;
    localparam logic [1:0] EV_OFF  = 2'd2;

    localparam int PIN_A = 0;
    localparam int PIN_B = 6;
    localparam int PIN_F = 3;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] address;
        logic [7:0] write_data;
        logic [7:0] ext_enable;
        logic [7:0] ext_level;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_request;
        logic [1:0] pin0_event;
        logic [1:0] pin6_event;
        logic [7:0] pin_levels;
    } result_t;

    typedef struct packed {
        logic [7:0] pin_in;
        logic [7:0] pin_out;
        logic [7:0] dir;
        logic [7:0] flag;
        logic [7:0] edge_select;
        logic [7:0] irq_enable;
        logic [7:0] select;
        logic [7:0] select2;
        logic [7:0] pull_enable;
        logic       shadow_p0;
        logic       shadow_p6;
        logic       shadow_p3;
    } port_state_t;

endpackage

[rtl/gpe_core.sv]
// Next-state and result logic for one bus access or evaluation tick.
module gpe_core
(
    input  gpe_pkg::port_state_t state,
    input  gpe_pkg::item_t       item,
    output gpe_pkg::port_state_t state_next,
    output gpe_pkg::result_t     result
);

    logic [7:0] pin_new;
    logic [7:0] rise;
    logic [7:0] fall;
    logic [7:0] edges;
    logic [7:0] read_mux;
    logic       mapped;

    always_comb
    begin
        mapped   = 1'b1;
        read_mux = 8'h00;
        case (item.address)
            gpe_pkg::ADDR_IN:   read_mux = state.pin_in;
            gpe_pkg::ADDR_OUT:  read_mux = state.pin_out;
            gpe_pkg::ADDR_DIR:  read_mux = state.dir;
            gpe_pkg::ADDR_IFG:  read_mux = state.flag;
            gpe_pkg::ADDR_IES:  read_mux = state.edge_select;
            gpe_pkg::ADDR_IE:   read_mux = state.irq_enable;
            gpe_pkg::ADDR_SEL:  read_mux = state.select;
            gpe_pkg::ADDR_REN:  read_mux = state.pull_enable;
            gpe_pkg::ADDR_SEL2: read_mux = state.select2;
            default:            mapped   = 1'b0;
        endcase
    end

    // Pulled inputs follow the output bit; external bias overrides both ways.
    assign pin_new = ((~state.dir & state.pull_enable & state.pin_out)
                      | (item.ext_enable & item.ext_level))
                     & ~(item.ext_enable & ~item.ext_level);
    assign rise  = ~state.pin_in & pin_new & ~state.edge_select;
    assign fall  = state.pin_in & ~pin_new & state.edge_select;
    assign edges = state.irq_enable & (rise | fall);

    always_comb
    begin
        state_next = state;
        result     = '0;
        case (item.command)
            gpe_pkg::CMD_WRITE:
            begin
                case (item.address)
                    gpe_pkg::ADDR_IN:   state_next.pin_in      = item.write_data;
                    gpe_pkg::ADDR_OUT:  state_next.pin_out     = item.write_data;
                    gpe_pkg::ADDR_DIR:  state_next.dir         = item.write_data;
                    gpe_pkg::ADDR_IFG:  state_next.flag        = item.write_data;
                    gpe_pkg::ADDR_IES:  state_next.edge_select = item.write_data;
                    gpe_pkg::ADDR_IE:   state_next.irq_enable  = item.write_data;
                    gpe_pkg::ADDR_SEL:  state_next.select      = item.write_data;
                    gpe_pkg::ADDR_REN:  state_next.pull_enable = item.write_data;
                    gpe_pkg::ADDR_SEL2: state_next.select2     = item.write_data;
                    default:            state_next = state;
                endcase
            end
            gpe_pkg::CMD_READ:
            begin
                result.read_data = mapped ? read_mux : 8'h00;
            end
            gpe_pkg::CMD_TICK:
            begin
                if (state.dir[gpe_pkg::PIN_A])
                begin
                    state_next.shadow_p0 = state.pin_out[gpe_pkg::PIN_A];
                    if (state.pin_out[gpe_pkg::PIN_A] && !state.shadow_p0)
                        result.pin0_event = gpe_pkg::EV_ON;
                    else if (!state.pin_out[gpe_pkg::PIN_A] && state.shadow_p0)
                        result.pin0_event = gpe_pkg::EV_OFF;
                end
                if (state.dir[gpe_pkg::PIN_B])
                begin
                    state_next.shadow_p6 = state.pin_out[gpe_pkg::PIN_B];
                    if (state.pin_out[gpe_pkg::PIN_B] && !state.shadow_p6)
                        result.pin6_event = gpe_pkg::EV_ON;
                    else if (!state.pin_out[gpe_pkg::PIN_B] && state.shadow_p6)
                        result.pin6_event = gpe_pkg::EV_OFF;
                end
                if (state.irq_enable[gpe_pkg::PIN_F])
                begin
                    state_next.shadow_p3 = state.flag[gpe_pkg::PIN_F];
                    if (state.flag[gpe_pkg::PIN_F] && !state.shadow_p3)
                        result.irq_request = 1'b1;
                end
                if (pin_new != state.pin_in)
                begin
                    state_next.pin_in = pin_new;
                    if ((edges != 8'h00) && (edges != state.flag))
                    begin
                        state_next.flag    = state.flag | edges;
                        result.irq_request = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
        result.pin_levels = state_next.pin_in;
    end

endmodule

[rtl/gpio_port_edge_interrupt_top.sv]
// Top level of the eight-pin GPIO port with edge interrupts.
// Each accepted beat's result is captured in the result register.
// Throughput: one beat per cycle unless result_ready stalls the output; the single port-state update sets that figure.
// The result register lets a new beat in while the previous result is taken.
// Reset (rst_n low, asynchronous) clears every port register, the shadow bits
// and the result valid flag.
module gpio_port_edge_interrupt_top
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  gpe_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output gpe_pkg::result_t result
);

    // All nine port registers and the three shadow bits live in one struct.
    gpe_pkg::port_state_t state_reg;
    gpe_pkg::port_state_t state_next;
    gpe_pkg::result_t     result_reg;
    gpe_pkg::result_t     result_next;
    logic                 valid_reg;
    logic                 accept;

    // The output register may be refilled in the same cycle its beat leaves.
    assign item_ready = !valid_reg || result_ready;
    assign accept     = item_valid && item_ready;

    // Every command is handled by a few byte-wide gates in one pass.
    gpe_core u_core
    (
        .state      (state_reg),
        .item       (item),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
                valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // The result payload needs no reset; it is qualified by valid_reg.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

[rtl/gpe_checker.sv]
// Port-level checker for the GPIO port, bound to the top level.
module gpe_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input gpe_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_ready,
    input gpe_pkg::result_t result
);

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> result_valid)
        else $error("accepted beat produced no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.command != gpe_pkg::CMD_TICK
        |=> !result.irq_request && result.pin0_event == gpe_pkg::EV_NONE
            && result.pin6_event == gpe_pkg::EV_NONE)
        else $error("event reported on a non-tick beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.command == gpe_pkg::CMD_READ
        && (item.address < gpe_pkg::ADDR_IN || item.address > gpe_pkg::ADDR_REN)
        && item.address != gpe_pkg::ADDR_SEL2
        |=> result.read_data == 8'h00)
        else $error("unmapped read returned nonzero data");

endmodule

bind gpio_port_edge_interrupt_top gpe_checker u_gpe_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
